FILE: sv/sat_pkg.sv
// Shared constants, register indexes and the saturating adder for the summed-area table.
package sat_pkg;

  localparam int MAX_COLS_DEF = 8192;

  localparam int SAMPLE_W  = 32;
  localparam int SUM_W     = 64;
  localparam int COLS_W    = 14;
  localparam int ROWS_W    = 17;
  localparam int ROW_POS_W = 16;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;

  // Wide enough for a column count up to 65536 and any 14-bit register value.
  localparam int CMP_W = 18;

  localparam logic [COLS_W-1:0] FRAME_COLS_RST = COLS_W'(8192);
  localparam logic [ROWS_W-1:0] FRAME_ROWS_RST = ROWS_W'(4096);
  localparam logic [ROWS_W-1:0] ROWS_LIMIT     = ROWS_W'(65536);

  typedef enum logic {
    REG_FRAME_COLS = 1'b0,
    REG_FRAME_ROWS = 1'b1
  } reg_idx_t;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage

FILE: sv/sat_line_store.sv
// Line store of the previous row's table values, with write-to-read bypass.
module sat_line_store
  import sat_pkg::*;
#(
  parameter int DEPTH  = MAX_COLS_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [SUM_W-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [SUM_W-1:0]  rd_data
);

  logic [SUM_W-1:0] mem [DEPTH];
  logic [SUM_W-1:0] q_r;
  logic [SUM_W-1:0] byp_data_r;
  logic             byp_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_r        <= mem[rd_addr];
      byp_data_r <= wr_data;
    end
  end

  // A read that collides with a write in the same cycle takes the new data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else if (rd_en) begin
      byp_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = byp_r ? byp_data_r : q_r;

endmodule

FILE: sv/summed_area_table_top.sv
// Streaming summed-area table: one request per sample in row-major order, one table value out.
// The block takes one sample request every clock cycle while in_stall is low; each accepted
// request passes the row-sum stage register and then the output register, which presents its
// table value. The line store read sits between the row sum and the final saturating add, and
// the input stalls only while both that stage and the output register are full and the output
// is stalled. The line store holds MAX_COLS entries of 64 bits, is not cleared after reset and
// is filled by the first row of each frame. Negative samples count as zero and all sums clamp
// at 2^64-1. frame_cols at byte address 0 and frame_rows at byte address 4 must be written
// over the APB port by the user only while the block is idle; the block itself does not
// enforce this. A count of zero acts as one and counts above the limits act as the limits.
module summed_area_table_top
  import sat_pkg::*;
#(
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [SUM_W-1:0]           out_table_sum,
  output logic                       out_end_of_row,
  output logic                       out_end_of_frame,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [CFG_AW-1:0]          paddr,
  input  logic [CFG_DW-1:0]          pwdata,
  output logic [CFG_DW-1:0]          prdata,
  output logic                       pready
);

  localparam int COL_W = $clog2(MAX_COLS);

  logic [COLS_W-1:0]    frame_cols_r;
  logic [ROWS_W-1:0]    frame_rows_r;

  logic [COL_W-1:0]     col_r, col_nxt;
  logic [ROW_POS_W-1:0] row_r, row_nxt;
  logic [SUM_W-1:0]     running_r, running_nxt;
  logic                 first_r, first_nxt;

  logic                 s1_valid_r;
  logic [SUM_W-1:0]     s1_row_sum_r;
  logic [COL_W-1:0]     s1_col_r;
  logic                 s1_first_r;
  logic                 s1_eor_r;
  logic                 s1_eof_r;

  logic                 out_valid_r;
  logic [SUM_W-1:0]     out_sum_r;
  logic                 out_eor_r;
  logic                 out_eof_r;

  logic                 accept;
  logic                 s1_adv;
  logic                 cfg_wr;
  logic [CMP_W-1:0]     cols_eff;
  logic [CMP_W-1:0]     col_inc;
  logic [ROWS_W-1:0]    rows_eff;
  logic [ROWS_W-1:0]    row_inc;
  logic                 eor;
  logic                 eof;
  logic [SUM_W-1:0]     sample_pos;
  logic [SUM_W-1:0]     row_sum;
  logic [SUM_W-1:0]     above_raw;
  logic [SUM_W-1:0]     above;
  logic [SUM_W-1:0]     s1_sum;

  // Handshakes
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign accept   = in_valid && !in_stall;
  assign out_valid        = out_valid_r;
  assign out_table_sum    = out_sum_r;
  assign out_end_of_row   = out_eor_r;
  assign out_end_of_frame = out_eof_r;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (reg_idx_t'(paddr[2]))
      REG_FRAME_COLS: prdata = CFG_DW'(frame_cols_r);
      REG_FRAME_ROWS: prdata = CFG_DW'(frame_rows_r);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_cols_r <= FRAME_COLS_RST;
      frame_rows_r <= FRAME_ROWS_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(paddr[2]))
        REG_FRAME_COLS: frame_cols_r <= pwdata[COLS_W-1:0];
        REG_FRAME_ROWS: frame_rows_r <= pwdata[ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  // Position tracking and the running row sum, evaluated for the accepted sample.
  always_comb begin
    if (frame_cols_r == '0) begin
      cols_eff = CMP_W'(1);
    end else if (CMP_W'(frame_cols_r) > CMP_W'(MAX_COLS)) begin
      cols_eff = CMP_W'(MAX_COLS);
    end else begin
      cols_eff = CMP_W'(frame_cols_r);
    end

    if (frame_rows_r == '0) begin
      rows_eff = ROWS_W'(1);
    end else if (frame_rows_r > ROWS_LIMIT) begin
      rows_eff = ROWS_LIMIT;
    end else begin
      rows_eff = frame_rows_r;
    end

    col_inc = CMP_W'(col_r) + CMP_W'(1);
    row_inc = ROWS_W'(row_r) + ROWS_W'(1);
    eor     = col_inc >= cols_eff;
    eof     = eor && (row_inc >= rows_eff);

    sample_pos = in_sample_value[SAMPLE_W-1] ? '0 : SUM_W'($unsigned(in_sample_value));
    row_sum    = sat_add(running_r, sample_pos);

    if (eor) begin
      col_nxt     = '0;
      running_nxt = '0;
      row_nxt     = eof ? '0 : row_inc[ROW_POS_W-1:0];
      first_nxt   = eof;
    end else begin
      col_nxt     = col_inc[COL_W-1:0];
      running_nxt = row_sum;
      row_nxt     = row_r;
      first_nxt   = first_r;
    end
  end

  sat_line_store #(
    .DEPTH  (MAX_COLS),
    .ADDR_W (COL_W)
  ) u_line_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (s1_adv),
    .wr_addr (s1_col_r),
    .wr_data (s1_sum),
    .rd_en   (accept),
    .rd_addr (col_r),
    .rd_data (above_raw)
  );

  // The first row of a frame has nothing above it.
  assign above  = s1_first_r ? '0 : above_raw;
  assign s1_sum = sat_add(s1_row_sum_r, above);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      running_r   <= '0;
      first_r     <= 1'b1;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        col_r     <= col_nxt;
        row_r     <= row_nxt;
        running_r <= running_nxt;
        first_r   <= first_nxt;
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_row_sum_r <= row_sum;
      s1_col_r     <= col_r;
      s1_first_r   <= first_r;
      s1_eor_r     <= eor;
      s1_eof_r     <= eof;
    end
    if (s1_adv) begin
      out_sum_r <= s1_sum;
      out_eor_r <= s1_eor_r;
      out_eof_r <= s1_eof_r;
    end
  end

endmodule

FILE: sv/sat_checker.sv
// Port-level checks for the summed-area table, bound to the top level.
module sat_checker
  import sat_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [SUM_W-1:0] out_table_sum,
  input logic             out_end_of_row,
  input logic             out_end_of_frame
);

  // A stalled result keeps its value and its markers.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_table_sum)
      && $stable(out_end_of_row) && $stable(out_end_of_frame))
    else $error("stalled result changed");

  // The last result of a frame also closes its row.
  a_eof_eor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_frame |-> out_end_of_row)
    else $error("end of frame without end of row");

  // The input side only stalls while a finished result is held back downstream.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with the output free");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("result pending after reset");

endmodule

bind summed_area_table_top sat_checker u_sat_checker (.*);
